FILE: design/msts_pkg.sv
// Shared types and constants for the multi-slot timer scheduler.
`timescale 1ns / 1ps
`default_nettype none
package msts_pkg;
  localparam int NUM_SLOTS  = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int ORD_W      = 16;
  localparam int FIRE_LIMIT = 32;
  localparam int FIRE_W     = 6;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_STARTED   = 3'd0,
    K_STOPPED   = 3'd1,
    K_FIRED     = 3'd2,
    K_NO_SLOT   = 3'd3,
    K_NOT_RUN   = 3'd4,
    K_TICK_DONE = 3'd5,
    K_RSV6      = 3'd6,
    K_RSV7      = 3'd7
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [30:0] delay;
    logic [30:0] period;
    logic [3:0]  timer_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] event_time;
    logic [4:0]  active_count;
    logic [4:0]  existing_count;
    logic [4:0]  free_count;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DEC,
    ST_FIRE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic tick;
    logic scan_clr;
    logic scan_step;
    logic fire;
    logic done;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    out_free;
    logic    scan_last;
    logic    found;
    logic    fire_last;
  } sts_t;
endpackage
`default_nettype wire

FILE: design/msts_ctrl.sv
// Controller state machine of the timer scheduler.
`timescale 1ns / 1ps
`default_nettype none
module msts_ctrl
  import msts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_NONE: state_nxt = ST_IDLE;
          OP_TICK: begin
            cmd.tick     = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
          default: begin
            if (sts.out_free) begin
              cmd.exec  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_DEC;
      end
      ST_DEC: state_nxt = sts.found ? ST_FIRE : ST_DONE;
      ST_FIRE: begin
        if (sts.out_free) begin
          cmd.fire     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = sts.fire_last ? ST_DONE : ST_SCAN;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/msts_dp.sv
// Datapath of the timer scheduler: slot table, free stack, scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module msts_dp
  import msts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  logic [TIME_BITS-1:0] exp_r [NUM_SLOTS];
  logic [TIME_BITS-1:0] rel_r [NUM_SLOTS];
  logic [ORD_W-1:0]     ord_r [NUM_SLOTS];
  logic [SLOT_W-1:0]    stk_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] run_r, run_nxt;

  in_word_t             inw_r;
  logic [TIME_BITS-1:0] cur_r, cur_nxt;
  logic [ORD_W-1:0]     oc_r, oc_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt, depth_r, depth_nxt, act_r, act_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [FIRE_W-1:0]    k_r, k_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_W-1:0]    best_r, best_nxt;
  logic [TIME_BITS-1:0] bexp_r, bexp_nxt, brel_r, brel_nxt, bage_r, bage_nxt;
  logic [ORD_W-1:0]     boag_r, boag_nxt;
  logic                 ov_r, ov_nxt;
  out_word_t            od_r, od_nxt;

  logic                 wr_en, push, stk_pop;
  logic [SLOT_W-1:0]    wr_slot, rel_slot;
  logic [TIME_BITS-1:0] wr_exp, wr_rel;
  logic [TIME_BITS-1:0] age_i;
  logic [ORD_W-1:0]     oag_i;
  logic                 cand;
  logic                 out_free;
  logic [SLOT_W-1:0]    top_idx;

  assign out_free  = !ov_r || out_ready;
  assign age_i     = cur_r - exp_r[idx_r];
  assign oag_i     = oc_r - ord_r[idx_r];
  assign cand      = run_r[idx_r] && !age_i[TIME_BITS-1] &&
                     (!found_r || age_i > bage_r || (age_i == bage_r && oag_i > boag_r));
  assign top_idx   = SLOT_W'(depth_r - CNT_W'(1));

  assign sts.op        = opcode_t'(inw_r.opcode);
  assign sts.out_free  = out_free;
  assign sts.scan_last = idx_r == SLOT_W'(NUM_SLOTS - 1);
  assign sts.found     = found_r;
  assign sts.fire_last = k_r == FIRE_W'(FIRE_LIMIT - 1);

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    cur_nxt   = cur_r;
    oc_nxt    = oc_r;
    used_nxt  = used_r;
    depth_nxt = depth_r;
    act_nxt   = act_r;
    run_nxt   = run_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    bexp_nxt  = bexp_r;
    brel_nxt  = brel_r;
    bage_nxt  = bage_r;
    boag_nxt  = boag_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    wr_en     = 1'b0;
    wr_slot   = best_r;
    wr_exp    = '0;
    wr_rel    = '0;
    push      = 1'b0;
    rel_slot  = best_r;
    stk_pop   = 1'b0;

    if (cmd.tick) begin
      cur_nxt = cur_r + TIME_BITS'(1);
      k_nxt   = '0;
    end
    if (cmd.scan_clr) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      idx_nxt = idx_r + SLOT_W'(1);
      if (cand) begin
        found_nxt = 1'b1;
        best_nxt  = idx_r;
        bexp_nxt  = exp_r[idx_r];
        brel_nxt  = rel_r[idx_r];
        bage_nxt  = age_i;
        boag_nxt  = oag_i;
      end
    end

    if (cmd.exec) begin
      ov_nxt            = 1'b1;
      od_nxt.slot_id    = '0;
      od_nxt.event_time = 32'(cur_r);
      od_nxt.last       = 1'b1;
      if (inw_r.opcode == OP_START) begin
        wr_slot = used_r[SLOT_W-1:0];
        if (depth_r != '0) begin
          wr_en     = 1'b1;
          stk_pop   = 1'b1;
          wr_slot   = stk_r[top_idx];
          depth_nxt = depth_r - CNT_W'(1);
        end else if (used_r < CNT_W'(NUM_SLOTS)) begin
          wr_en    = 1'b1;
          used_nxt = used_r + CNT_W'(1);
        end
        if (wr_en) begin
          wr_exp            = cur_r + TIME_BITS'(inw_r.delay);
          wr_rel            = TIME_BITS'(inw_r.period);
          oc_nxt            = oc_r + ORD_W'(1);
          run_nxt[wr_slot]  = 1'b1;
          act_nxt           = act_r + CNT_W'(1);
          od_nxt.kind       = K_STARTED;
          od_nxt.slot_id    = wr_slot;
          od_nxt.event_time = 32'(wr_exp);
        end else begin
          od_nxt.kind = K_NO_SLOT;
        end
      end else begin
        od_nxt.slot_id = inw_r.timer_id;
        rel_slot       = inw_r.timer_id;
        if (run_r[inw_r.timer_id]) begin
          push        = 1'b1;
          od_nxt.kind = K_STOPPED;
        end else begin
          od_nxt.kind = K_NOT_RUN;
        end
      end
    end

    if (cmd.fire) begin
      ov_nxt            = 1'b1;
      od_nxt.kind       = K_FIRED;
      od_nxt.slot_id    = best_r;
      od_nxt.event_time = 32'(bexp_r);
      od_nxt.last       = 1'b0;
      k_nxt             = k_r + FIRE_W'(1);
      if (brel_r == '0) begin
        push = 1'b1;
      end else begin
        wr_en   = 1'b1;
        wr_slot = best_r;
        wr_exp  = bexp_r + brel_r;
        wr_rel  = brel_r;
        oc_nxt  = oc_r + ORD_W'(1);
      end
    end

    if (push) begin
      run_nxt[rel_slot] = 1'b0;
      act_nxt           = act_r - CNT_W'(1);
      if (depth_r < CNT_W'(NUM_SLOTS)) depth_nxt = depth_r + CNT_W'(1);
    end

    if (cmd.done) begin
      ov_nxt            = 1'b1;
      od_nxt.kind       = K_TICK_DONE;
      od_nxt.slot_id    = '0;
      od_nxt.event_time = 32'(cur_r);
      od_nxt.last       = 1'b1;
    end

    if (cmd.exec || cmd.fire || cmd.done) begin
      od_nxt.active_count   = act_nxt;
      od_nxt.existing_count = used_nxt;
      od_nxt.free_count     = depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      oc_r    <= '0;
      used_r  <= '0;
      depth_r <= '0;
      act_r   <= '0;
      run_r   <= '0;
      idx_r   <= '0;
      k_r     <= '0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      cur_r   <= cur_nxt;
      oc_r    <= oc_nxt;
      used_r  <= used_nxt;
      depth_r <= depth_nxt;
      act_r   <= act_nxt;
      run_r   <= run_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) inw_r <= in_data;
    best_r <= best_nxt;
    bexp_r <= bexp_nxt;
    brel_r <= brel_nxt;
    bage_r <= bage_nxt;
    boag_r <= boag_nxt;
    od_r   <= od_nxt;
    if (wr_en) begin
      exp_r[wr_slot] <= wr_exp;
      rel_r[wr_slot] <= wr_rel;
      ord_r[wr_slot] <= oc_r;
    end
    if (push && depth_r < CNT_W'(NUM_SLOTS)) stk_r[depth_r[SLOT_W-1:0]] <= rel_slot;
  end

  // A popped stack entry is never pushed in the same cycle.
  a_pop_push: assert property (@(posedge clk) disable iff (!rst_n) !(stk_pop && push))
    else $error("free stack popped and pushed together");
  // Every handed-out slot is either running or on the free stack.
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r + depth_r) == used_r)
    else $error("slot accounting out of balance");
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    act_r == CNT_W'($countones(run_r)))
    else $error("active count disagrees with running flags");
  a_fire_lim: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= FIRE_W'(FIRE_LIMIT))
    else $error("fire limit exceeded");
endmodule
`default_nettype wire

FILE: design/multi_slot_timer_scheduler_core.sv
// Top level of the multi-slot timer scheduler.
`timescale 1ns / 1ps
`default_nettype none
// Sixteen-slot one-shot and periodic timer block. Words on the input carry a start, a stop, a
// tick or no operation. Start and stop each give one result word, written to the output register
// once it is free, and the controller returns to idle for the next input word as it is written.
// A tick scans the slot table one slot per cycle, so each fired timer costs a full scan of all
// slots, a decision state and a fire state; at most 32 fires per tick. One word is worked on at
// a time; a new input word is taken while the previous result still waits in the output
// register.
module multi_slot_timer_scheduler_core
  import msts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  cmd_t cmd;
  sts_t sts;

  msts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire
